// ===== hdl/frl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frl_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 15;
   localparam int LEVEL_MAX   = 32767;
   localparam int FRL_MAX_FRAME = 512;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;       // input transaction, accumulate sample
      logic div_load;   // start divide, clear frame accumulators
      logic div_step;   // one quotient bit
      logic sqrt_load;  // start square root from the quotient
      logic sqrt_step;  // one root bit
      logic out_load;   // move the root into the result register
   } frl_cmd_type;

   typedef struct packed {
      logic step_last;  // iteration counter at its final step
   } frl_stat_type;

endpackage

`default_nettype wire

// ===== hdl/frl_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface frl_req_if;
   import frl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       frame_end;

   modport source (output valid, sample, frame_end, input ready);
   modport sink   (input valid, sample, frame_end, output ready);
endinterface

interface frl_rsp_if;
   import frl_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] rms_level;
   logic               frame_too_long;

   modport source (output valid, rms_level, frame_too_long, input ready);
   modport sink   (input valid, rms_level, frame_too_long, output ready);
endinterface

`default_nettype wire

// ===== hdl/frl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frl_datapath #(
   parameter int MAX_FRAME = frl_pkg::FRL_MAX_FRAME
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frl_pkg::frl_cmd_type                cmd,
   input  logic signed [frl_pkg::SAMPLE_W-1:0] sample,
   output frl_pkg::frl_stat_type               stat,
   output logic [frl_pkg::LEVEL_W-1:0]         rms_level,
   output logic                                frame_too_long
);
   import frl_pkg::*;

   localparam int CNT_W    = $clog2(MAX_FRAME + 1);
   localparam int SUM_W    = 31 + $clog2(MAX_FRAME);
   localparam int SQ_STEPS = (SUM_W + 1) / 2;
   localparam int ROOT_W   = SQ_STEPS;
   localparam int RAD_W    = 2 * SQ_STEPS;
   localparam int STEP_W   = $clog2(SUM_W);

   // accumulation
   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] sq_ff;
   logic                  sq_valid_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      count_ff;
   logic                  ovf_ff;
   logic                  room;

   // divider
   logic [SUM_W-1:0]      quo_ff;
   logic [CNT_W-1:0]      rem_ff, den_ff;
   logic [CNT_W:0]        rem_sh, rem_diff;
   logic                  too_long_ff;

   // square root
   logic [RAD_W-1:0]      rad_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [ROOT_W+1:0]     srem_ff, srem_sh, trial, srem_diff;
   logic                  sq_ge;

   logic [STEP_W-1:0]     step_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic                  flag_ff;

   assign mag    = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
   assign room   = count_ff < CNT_W'(MAX_FRAME);
   assign sum_in = sum_ff + (sq_valid_ff ? SUM_W'(sq_ff) : SUM_W'(0));

   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   assign srem_sh   = {srem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign sq_ge     = srem_sh >= trial;
   assign srem_diff = srem_sh - trial;

   assign stat.step_last = step_ff == '0;
   assign rms_level      = level_ff;
   assign frame_too_long = flag_ff;

   always_ff @(posedge clock) begin
      // squaring stage, added into the sum in the next cycle
      sq_ff <= (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);

      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else if (cmd.div_load) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.take && room;
         sum_ff      <= sum_in;
         if (cmd.take) begin
            if (room) count_ff <= count_ff + CNT_W'(1);
            else      ovf_ff   <= 1'b1;
         end
      end

      if (cmd.div_load) begin
         quo_ff      <= sum_in;
         rem_ff      <= '0;
         den_ff      <= count_ff;
         too_long_ff <= ovf_ff;
         step_ff     <= STEP_W'(SUM_W - 1);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_diff[CNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[CNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_ff <= step_ff - STEP_W'(1);
      end else if (cmd.sqrt_load) begin
         rad_ff  <= RAD_W'(quo_ff);
         root_ff <= '0;
         srem_ff <= '0;
         step_ff <= STEP_W'(SQ_STEPS - 1);
      end else if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sq_ge ? srem_diff : srem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
         step_ff <= step_ff - STEP_W'(1);
      end

      if (cmd.out_load) begin
         level_ff <= (root_ff > ROOT_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                    : root_ff[LEVEL_W-1:0];
         flag_ff  <= too_long_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME))
      else $error("sample count beyond frame limit");

   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> (sum_ff == '0) && (count_ff == '0) && !ovf_ff)
      else $error("accumulators not cleared at frame end");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < den_ff)
      else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== hdl/frl_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frl_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_frame_end,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  frl_pkg::frl_stat_type stat,
   output frl_pkg::frl_cmd_type  cmd
);
   import frl_pkg::*;

   typedef enum logic [2:0] {
      ACCUM,
      DRAIN,
      DIV,
      ROOT_INIT,
      ROOT,
      DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == ACCUM;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ACCUM: begin
            cmd.take = req_valid;
            if (req_valid && req_frame_end) state_in = DRAIN;
         end
         DRAIN: begin
            cmd.div_load = 1'b1;
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (stat.step_last) state_in = ROOT_INIT;
         end
         ROOT_INIT: begin
            cmd.sqrt_load = 1'b1;
            state_in      = ROOT;
         end
         ROOT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.step_last) state_in = DELIVER;
         end
         DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ACCUM;
            end
         end
         default: state_in = ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_frame_end_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_frame_end) |=> state_ff == DRAIN)
      else $error("frame end not followed by drain");

   a_div_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV && stat.step_last) |=> state_ff == ROOT_INIT)
      else $error("divide did not hand over to square root");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DELIVER))
      else $error("result raised outside delivery");

endmodule

`default_nettype wire

// ===== hdl/frame_rms_level.sv =====
// Block RMS level meter. Each req transaction carries one signed 16-bit sample and a
// frame_end flag; every sample up to MAX_FRAME per frame is squared and summed, and
// further samples only set frame_too_long. The transaction with frame_end produces
// one rsp transaction with floor(sqrt(floor(sum / count))), saturated to 32767.
// Samples are taken one per cycle while the block accumulates. After a frame end the
// block stops taking samples while it runs its back end: a drain state, the restoring
// divider with one step per bit of the sum (31 + clog2(MAX_FRAME) bits), a load state,
// the square root with one step per bit pair, and the load of the result register.
// The result register lets the next frame's samples flow while a result waits on
// rsp; a second frame end waits at the result load until the earlier result is taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_rms_level #(
   parameter int MAX_FRAME = frl_pkg::FRL_MAX_FRAME
) (
   input  logic      clock,
   input  logic      reset,
   frl_req_if.sink   req_chan,
   frl_rsp_if.source rsp_chan
);
   import frl_pkg::*;

   frl_cmd_type  cmd;    // per-cycle datapath commands
   frl_stat_type stat;   // iteration status back to the controller

   // sequencer: accumulate, divide, square root, deliver
   frl_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_frame_end (req_chan.frame_end),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // squarer, accumulator, serial divider, serial root, result register
   frl_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample         (req_chan.sample),
      .stat           (stat),
      .rms_level      (rsp_chan.rms_level),
      .frame_too_long (rsp_chan.frame_too_long)
   );

endmodule

`default_nettype wire
